FILE: design/ppm_symbol_frame_decoder_macros.svh
// Assertion macros for the pulse frame decoder.
`ifndef PPM_SYMBOL_FRAME_DECODER_MACROS_SVH
`define PPM_SYMBOL_FRAME_DECODER_MACROS_SVH

`ifndef SYNTH
// a holds in a cycle -> b holds in the same cycle
`define PSFD_ASSERT_SAME(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed: a |-> b");
// a holds in a cycle -> b holds in the next cycle
`define PSFD_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed: a |=> b");
`else
`define PSFD_ASSERT_SAME(label, clk, rst_n, a, b)
`define PSFD_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif

`endif

FILE: design/psfd_pkg.sv
`default_nettype none

package psfd_pkg;

    localparam logic [8:0]  MAX_BYTES = 9'd258;
    localparam logic [15:0] MIN_TOTAL = 16'd18;  // 4.5 us in ticks
    localparam logic [15:0] MAX_TOTAL = 16'd90;  // 22.5 us in ticks
    localparam logic [1:0]  SYM_MASK  = 2'h3;

    // register indexes on the configuration port
    localparam logic [1:0] CFG_SESSION = 2'd0;
    localparam logic [1:0] CFG_PAGE    = 2'd1;
    localparam logic [1:0] CFG_STEP    = 2'd2;

    localparam logic [6:0] STEP_RESET = 7'd6;

    typedef enum logic [1:0] {
        KIND_BYTE   = 2'd0,
        KIND_DONE   = 2'd1,
        KIND_REJECT = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_DECODE  = 2'd1,
        PH_DISCARD = 2'd2
    } phase_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_DIV,
        ST_PACK,
        ST_REJECT,
        ST_BYTE,
        ST_FLUSH,
        ST_DONE
    } state_t;

    typedef enum logic [2:0] {
        EMIT_NONE,
        EMIT_REJECT,
        EMIT_BYTE,
        EMIT_FLUSH,
        EMIT_DONE
    } emit_t;

    typedef struct packed {
        logic  load_in;
        logic  hdr_accept;
        logic  set_halted;
        logic  div_start;
        logic  div_step;
        logic  pack;
        emit_t emit;
    } cmd_t;

    typedef struct packed {
        logic eof;
        logic hdr_match;
        logic in_range;
        logic halted;
        logic pairs_partial;
        logic pairs_three;
        logic bytes_full;
        logic div_last;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

FILE: design/ppm_symbol_frame_decoder.sv
// Two-bit pulse-position frame decoder.
//
// Input channel (in_valid/in_ready): one received pulse per transfer, as
// high_ticks and low_ticks in quarter-microsecond ticks plus end_of_frame on
// the closing pulse. The first pulse of a frame is the header.
// Output channel (out_valid/out_ready): data bytes, a frame-done record and
// header-rejected records; last_of_run marks the final result of one pulse.
// Configuration: cfg_we/cfg_index/cfg_data write the session length, page
// length and symbol step; write only while the block is idle.
//
// One pulse at a time. A header, discarded or skipped pulse is loaded and
// classified, then emits its results, if any, before the next pulse is taken.
// A data pulse is loaded and classified, passes through the 2-bit-per-cycle
// restoring divider and is packed, then emits a byte when it completes one.
// The output register lets the next pulse be taken while a result waits; a
// stalled receiver holds the decoder in its emit state until the result moves.
// Reset clears the phase to header search, the step to 6 and both header
// lengths to zero, which rejects every header until they are written.
`default_nettype none

`include "ppm_symbol_frame_decoder_macros.svh"

module ppm_symbol_frame_decoder (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [14:0] high_ticks,
    input  wire logic [14:0] low_ticks,
    input  wire logic        end_of_frame,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       kind,
    output logic [7:0]       data_byte,
    output logic             frame_kind,
    output logic [8:0]       byte_count,
    output logic             stopped_early,
    output logic             last_of_run,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);
    import psfd_pkg::*;

    cmd_t    cmd;
    status_t status;

    // sequencer: phase tracking and command issue
    psfd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath: config, header windows, divider, byte packing, output register
    psfd_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .high_ticks    (high_ticks),
        .low_ticks     (low_ticks),
        .end_of_frame  (end_of_frame),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .cmd           (cmd),
        .status        (status),
        .out_ready     (out_ready),
        .out_valid     (out_valid),
        .kind          (kind),
        .data_byte     (data_byte),
        .frame_kind    (frame_kind),
        .byte_count    (byte_count),
        .stopped_early (stopped_early),
        .last_of_run   (last_of_run)
    );

    // one pulse at a time: a transfer drops ready for the next cycle
    `PSFD_ASSERT_NEXT(a_one_pulse, clk, rst_n, in_valid && in_ready, !in_ready)
    // never load a result over one that has not been transferred
    `PSFD_ASSERT_SAME(a_emit_free, clk, rst_n, cmd.emit != EMIT_NONE, status.out_free)
    // frame-done count never exceeds the buffer size
    `PSFD_ASSERT_SAME(a_count_max, clk, rst_n, out_valid && (kind == KIND_DONE), byte_count <= MAX_BYTES)

endmodule

`default_nettype wire

FILE: design/psfd_datapath.sv
`default_nettype none

module psfd_datapath (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [14:0]       high_ticks,
    input  wire logic [14:0]       low_ticks,
    input  wire logic              end_of_frame,
    input  wire logic              cfg_we,
    input  wire logic [1:0]        cfg_index,
    input  wire logic [15:0]       cfg_data,
    input  wire psfd_pkg::cmd_t    cmd,
    output psfd_pkg::status_t      status,
    input  wire logic              out_ready,
    output logic                   out_valid,
    output logic [1:0]             kind,
    output logic [7:0]             data_byte,
    output logic                   frame_kind,
    output logic [8:0]             byte_count,
    output logic                   stopped_early,
    output logic                   last_of_run
);
    import psfd_pkg::*;

    logic [15:0] session_reg;
    logic [15:0] page_reg;
    logic [6:0]  step_reg;

    logic [15:0] total_reg;
    logic        eof_reg;
    logic        header_type_reg;
    logic        halted_reg;
    logic [7:0]  shift_reg;
    logic [2:0]  pairs_reg;
    logic [8:0]  bytes_reg;

    logic [6:0]  rem_reg;
    logic [7:0]  dvd_reg;
    logic [7:0]  quo_reg;
    logic [1:0]  dcnt_reg;

    logic        out_valid_reg;
    kind_t       kind_reg;
    logic [7:0]  data_reg;
    logic        fk_reg;
    logic [8:0]  cnt_reg;
    logic        stop_reg;
    logic        last_reg;

    logic [6:0]  step_eff;
    logic [5:0]  half;
    logic        session_match;
    logic        page_match;
    logic [15:0] diff;
    logic [7:0]  partial_byte;
    logic        stop_calc;
    logic        out_free;
    logic [6:0]  rem_next;
    logic [7:0]  dvd_next;
    logic [7:0]  quo_next;

    function automatic logic in_window(input logic [15:0] sum, input logic [15:0] nominal,
                                       input logic [5:0] hw);
        logic [16:0] lo_side;
        logic [16:0] hi_side;
        lo_side = {1'b0, sum} + {11'b0, hw};
        hi_side = {1'b0, nominal} + {11'b0, hw};
        return (nominal != 16'd0) && (lo_side > {1'b0, nominal}) && ({1'b0, sum} < hi_side);
    endfunction

    assign step_eff      = (step_reg == 7'd0) ? 7'd1 : step_reg;
    assign half          = step_eff[6:1];
    assign session_match = in_window(total_reg, session_reg, half);
    assign page_match    = in_window(total_reg, page_reg, half);
    assign diff          = total_reg - MIN_TOTAL;
    assign out_free      = !out_valid_reg || out_ready;

    assign status.eof           = eof_reg;
    assign status.hdr_match     = session_match || page_match;
    assign status.in_range      = (total_reg >= MIN_TOTAL) && (total_reg <= MAX_TOTAL);
    assign status.halted        = halted_reg;
    assign status.pairs_partial = pairs_reg inside {[3'd1:3'd3]};
    assign status.pairs_three   = (pairs_reg == 3'd3);
    assign status.bytes_full    = (bytes_reg >= MAX_BYTES);
    assign status.div_last      = (dcnt_reg == 2'd3);
    assign status.out_free      = out_free;

    assign stop_calc = halted_reg || (status.pairs_partial && status.bytes_full);

    // left-align a partial byte
    always_comb
    begin
        case (pairs_reg)
            3'd1:    partial_byte = {shift_reg[1:0], 6'b0};
            3'd2:    partial_byte = {shift_reg[3:0], 4'b0};
            3'd3:    partial_byte = {shift_reg[5:0], 2'b0};
            default: partial_byte = 8'd0;
        endcase
    end

    // two restoring division steps per cycle
    always_comb
    begin
        logic [7:0] trial;
        logic       ge;
        rem_next = rem_reg;
        dvd_next = dvd_reg;
        quo_next = quo_reg;
        for (int i = 0; i < 2; i++)
        begin
            trial    = {rem_next, dvd_next[7]};
            dvd_next = {dvd_next[6:0], 1'b0};
            ge       = (trial >= {1'b0, step_eff});
            if (ge)
            begin
                trial = trial - {1'b0, step_eff};
            end
            rem_next = trial[6:0];
            quo_next = {quo_next[6:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            session_reg     <= 16'd0;
            page_reg        <= 16'd0;
            step_reg        <= STEP_RESET;
            header_type_reg <= 1'b0;
            halted_reg      <= 1'b0;
            shift_reg       <= 8'd0;
            pairs_reg       <= 3'd0;
            bytes_reg       <= 9'd0;
            dcnt_reg        <= 2'd0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_SESSION: session_reg <= cfg_data;
                    CFG_PAGE:    page_reg    <= cfg_data;
                    CFG_STEP:    step_reg    <= cfg_data[6:0];
                    default:     ;
                endcase
            end

            if (cmd.hdr_accept)
            begin
                header_type_reg <= !session_match;
                halted_reg      <= 1'b0;
                shift_reg       <= 8'd0;
                pairs_reg       <= 3'd0;
                bytes_reg       <= 9'd0;
            end

            if (cmd.set_halted)
            begin
                halted_reg <= 1'b1;
            end

            if (cmd.div_start)
            begin
                dcnt_reg <= 2'd0;
            end
            else if (cmd.div_step)
            begin
                dcnt_reg <= dcnt_reg + 2'd1;
            end

            if (cmd.pack)
            begin
                shift_reg <= {shift_reg[5:0], quo_reg[1:0] & SYM_MASK};
                pairs_reg <= pairs_reg + 3'd1;
            end

            case (cmd.emit)
                EMIT_BYTE, EMIT_FLUSH:
                begin
                    bytes_reg <= bytes_reg + 9'd1;
                    shift_reg <= 8'd0;
                    pairs_reg <= 3'd0;
                end
                EMIT_DONE:
                begin
                    shift_reg <= 8'd0;
                    pairs_reg <= 3'd0;
                end
                default: ;
            endcase

            if (cmd.emit != EMIT_NONE)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            total_reg <= {1'b0, high_ticks} + {1'b0, low_ticks};
            eof_reg   <= end_of_frame;
        end

        if (cmd.div_start)
        begin
            rem_reg <= 7'd0;
            dvd_reg <= {1'b0, diff[6:0]};
            quo_reg <= 8'd0;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= rem_next;
            dvd_reg <= dvd_next;
            quo_reg <= quo_next;
        end

        case (cmd.emit)
            EMIT_REJECT:
            begin
                kind_reg <= KIND_REJECT;
                data_reg <= 8'd0;
                fk_reg   <= 1'b0;
                cnt_reg  <= 9'd0;
                stop_reg <= 1'b0;
                last_reg <= 1'b1;
            end
            EMIT_BYTE:
            begin
                kind_reg <= KIND_BYTE;
                data_reg <= shift_reg;
                fk_reg   <= header_type_reg;
                cnt_reg  <= 9'd0;
                stop_reg <= 1'b0;
                last_reg <= 1'b1;
            end
            EMIT_FLUSH:
            begin
                kind_reg <= KIND_BYTE;
                data_reg <= partial_byte;
                fk_reg   <= header_type_reg;
                cnt_reg  <= 9'd0;
                stop_reg <= 1'b0;
                last_reg <= 1'b0;
            end
            EMIT_DONE:
            begin
                kind_reg <= KIND_DONE;
                data_reg <= 8'd0;
                fk_reg   <= header_type_reg;
                cnt_reg  <= bytes_reg;
                stop_reg <= stop_calc;
                last_reg <= 1'b1;
            end
            default: ;
        endcase
    end

    assign out_valid     = out_valid_reg;
    assign kind          = kind_reg;
    assign data_byte     = data_reg;
    assign frame_kind    = fk_reg;
    assign byte_count    = cnt_reg;
    assign stopped_early = stop_reg;
    assign last_of_run   = last_reg;

endmodule

`default_nettype wire

FILE: design/psfd_ctrl.sv
`default_nettype none

module psfd_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire psfd_pkg::status_t status,
    output psfd_pkg::cmd_t         cmd
);
    import psfd_pkg::*;

    state_t state_reg;
    state_t state_next;
    phase_t phase_reg;
    phase_t phase_next;
    logic   flush_ok;

    assign flush_ok = status.pairs_partial && !status.bytes_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= PH_HEADER;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                case (phase_reg)
                    PH_HEADER:
                    begin
                        if (status.hdr_match)
                        begin
                            if (status.eof)
                            begin
                                state_next = ST_DONE;
                            end
                            else
                            begin
                                state_next = ST_IDLE;
                                phase_next = PH_DECODE;
                            end
                        end
                        else
                        begin
                            state_next = ST_REJECT;
                            phase_next = status.eof ? PH_HEADER : PH_DISCARD;
                        end
                    end
                    PH_DECODE:
                    begin
                        if (status.eof)
                        begin
                            state_next = flush_ok ? ST_FLUSH : ST_DONE;
                            phase_next = PH_HEADER;
                        end
                        else if (status.halted || !status.in_range)
                        begin
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            state_next = ST_DIV;
                        end
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                        if (status.eof)
                        begin
                            phase_next = PH_HEADER;
                        end
                    end
                endcase
            end
            ST_DIV:
            begin
                if (status.div_last)
                begin
                    state_next = ST_PACK;
                end
            end
            ST_PACK:
            begin
                if (status.pairs_three && !status.bytes_full)
                begin
                    state_next = ST_BYTE;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_REJECT, ST_BYTE, ST_DONE:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_FLUSH:
            begin
                if (status.out_free)
                begin
                    state_next = ST_DONE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // commands
    always_comb
    begin
        cmd      = '0;
        cmd.emit = EMIT_NONE;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.load_in = in_valid;
            end
            ST_EVAL:
            begin
                case (phase_reg)
                    PH_HEADER:
                    begin
                        cmd.hdr_accept = status.hdr_match;
                    end
                    PH_DECODE:
                    begin
                        if (!status.eof && !status.halted)
                        begin
                            cmd.set_halted = !status.in_range;
                            cmd.div_start  = status.in_range;
                        end
                    end
                    default: ;
                endcase
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
            end
            ST_PACK:
            begin
                cmd.pack       = 1'b1;
                cmd.set_halted = status.pairs_three && status.bytes_full;
            end
            ST_REJECT:
            begin
                cmd.emit = status.out_free ? EMIT_REJECT : EMIT_NONE;
            end
            ST_BYTE:
            begin
                cmd.emit = status.out_free ? EMIT_BYTE : EMIT_NONE;
            end
            ST_FLUSH:
            begin
                cmd.emit = status.out_free ? EMIT_FLUSH : EMIT_NONE;
            end
            ST_DONE:
            begin
                cmd.emit = status.out_free ? EMIT_DONE : EMIT_NONE;
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire
